// ===== rtl/kct_pkg.sv =====
`default_nettype none

package kct_pkg;

  localparam logic [3:0] KEY_HASH  = 4'd10;
  localparam logic [3:0] KEY_PLUS  = 4'd11;
  localparam logic [3:0] KEY_MINUS = 4'd12;
  localparam logic [3:0] KEY_CLEAR = 4'd13;

  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam logic [5:0] SECS_MAX     = 6'd59;
  localparam logic [3:0] DEC_BASE     = 4'd10;

  typedef struct packed {
    logic       cmd;
    logic [3:0] key;
  } in_t;

  typedef struct packed {
    logic        running;
    logic        active;
    logic        expired;
    logic [12:0] remaining_secs;
    logic [6:0]  show_minutes;
    logic [5:0]  show_seconds;
    logic [3:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic [3:0]  second_tens;
    logic [3:0]  second_ones;
  } out_t;

  // digits[0] is seconds ones, digits[3] is minutes tens
  // show_minutes / show_seconds track seconds_left as a borrow counter
  typedef struct packed {
    logic            run_mode;
    logic            ticking;
    logic [3:0][3:0] digits;
    logic [1:0]      entered_count;
    logic [12:0]     seconds_left;
    logic [6:0]      show_minutes;
    logic [5:0]      show_seconds;
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/kct_step.sv =====
`default_nettype none

module kct_step (
  input  kct_pkg::state_t st,
  input  kct_pkg::in_t    item,
  output kct_pkg::state_t st_next,
  output kct_pkg::out_t   res
);

  logic [6:0]  load_mins;
  logic [6:0]  load_secs;
  logic [12:0] load_total;
  logic        load_carry;
  logic        expired;
  logic        go_entry;

  // mm:ss buffer to seconds, seconds field may reach 99
  assign load_mins  = 7'(st.digits[3]) * 7'(kct_pkg::DEC_BASE) + 7'(st.digits[2]);
  assign load_secs  = 7'(st.digits[1]) * 7'(kct_pkg::DEC_BASE) + 7'(st.digits[0]);
  assign load_total = 13'(load_mins) * 13'(kct_pkg::SECS_PER_MIN) + 13'(load_secs);
  assign load_carry = (load_secs >= 7'(kct_pkg::SECS_PER_MIN));

  always_comb begin
    st_next  = st;
    expired  = 1'b0;
    go_entry = 1'b0;
    if (item.cmd) begin
      if (st.run_mode && st.ticking) begin
        if (st.seconds_left != 13'd0) begin
          st_next.seconds_left = st.seconds_left - 13'd1;
          if (st.show_seconds == 6'd0) begin
            st_next.show_seconds = kct_pkg::SECS_MAX;
            st_next.show_minutes = st.show_minutes - 7'd1;
          end else begin
            st_next.show_seconds = st.show_seconds - 6'd1;
          end
          expired  = (st.seconds_left == 13'd1);
          go_entry = expired;
        end else begin
          go_entry = 1'b1;
        end
      end
    end else if (item.key == kct_pkg::KEY_CLEAR) begin
      go_entry = 1'b1;
    end else if (!st.run_mode) begin
      if (item.key < kct_pkg::DEC_BASE) begin
        for (int i = 1; i < 4; i++) begin
          if (st.entered_count >= 2'(i)) begin
            st_next.digits[i] = st.digits[i-1];
          end
        end
        st_next.digits[0] = item.key;
        if (st.entered_count != 2'd3) begin
          st_next.entered_count = st.entered_count + 2'd1;
        end
      end else if (item.key == kct_pkg::KEY_HASH) begin
        st_next.seconds_left = load_total;
        st_next.show_minutes = load_mins + 7'(load_carry);
        st_next.show_seconds = load_carry ? 6'(load_secs - 7'(kct_pkg::SECS_PER_MIN))
                                          : 6'(load_secs);
        st_next.run_mode     = 1'b1;
        st_next.ticking      = 1'b1;
        go_entry             = (load_total == 13'd0);
      end else if (item.key == kct_pkg::KEY_MINUS) begin
        go_entry = 1'b1;
      end
    end else begin
      if (item.key == kct_pkg::KEY_PLUS) begin
        st_next.ticking = ~st.ticking;
      end else if (item.key == kct_pkg::KEY_MINUS) begin
        go_entry = 1'b1;
      end
    end
    if (go_entry) begin
      st_next = '0;
    end
  end

  always_comb begin
    res.running        = st_next.run_mode;
    res.active         = st_next.ticking;
    res.expired        = expired;
    res.remaining_secs = st_next.seconds_left;
    res.show_minutes   = st_next.show_minutes;
    res.show_seconds   = st_next.show_seconds;
    res.minute_tens    = st_next.digits[3];
    res.minute_ones    = st_next.digits[2];
    res.second_tens    = st_next.digits[1];
    res.second_ones    = st_next.digits[0];
  end

endmodule

`default_nettype wire

// ===== rtl/keypad_countdown_timer_unit.sv =====
// result_valid rises when the accepted input transaction advances from the input register
// into the result register; while the result is stalled, the transaction waits in the input register
// throughput: one transaction per cycle while result_stall is low, set by the combinational state update
// a waiting result does not block the input register; it stalls only when both are full
// rst (synchronous) empties both registers and puts the timer in entry mode, all zero
`default_nettype none

module keypad_countdown_timer_unit (
  input  wire              clk,
  input  wire              rst,
  input  wire              item_valid,
  output logic             item_stall,
  input  kct_pkg::in_t     item,
  output logic             result_valid,
  input  wire              result_stall,
  output kct_pkg::out_t    result
);

  logic            held_valid;
  kct_pkg::in_t    held;
  kct_pkg::state_t st;
  kct_pkg::state_t st_next;
  kct_pkg::out_t   res;
  logic            advance;

  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  kct_step u_step (
    .st      (st),
    .item    (held),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      st           <= st_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  // minute/second counters must stay in step with the seconds count
  a_split_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.remaining_secs ==
      13'(result.show_minutes) * 13'd60 + 13'(result.show_seconds)))
    else $error("mm:ss display out of step with remaining seconds");

  a_entry_idle: assert property (@(posedge clk) disable iff (rst)
    !st.run_mode |-> (!st.ticking && st.seconds_left == 13'd0))
    else $error("entry mode with live countdown state");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.run_mode |-> (st.seconds_left != 13'd0))
    else $error("counting with zero seconds left");

  a_expire_to_entry: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.expired) |->
      (!result.running && !result.active && result.remaining_secs == 13'd0))
    else $error("expired without return to entry mode");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(st))
    else $error("timer state changed with no transaction");

endmodule

`default_nettype wire
